// ===== design/atci_pkg.sv =====
// Shared types and constants for the ATA task-file command issuer.
package atci_pkg;

    // Request word taken on the command channel
    typedef struct packed {
        logic [1:0]  device_index;
        logic        write_request;
        logic [31:0] block_address;
        logic [7:0]  sector_total;
    } request_t;

    // Task-file write word given on the result channel
    typedef struct packed {
        logic        target_channel;
        logic [2:0]  register_code;
        logic [7:0]  write_value;
        logic        final_write;
    } taskfile_write_t;

    // Classified request passed from front to back
    typedef struct packed {
        logic        channel;
        logic        ext;
        logic [7:0]  count;
        logic [7:0]  devsel;
        logic [7:0]  hob_low;
        logic [7:0]  byte_low;
        logic [7:0]  byte_mid;
        logic [7:0]  byte_high;
        logic [7:0]  opcode;
    } issue_desc_t;

    // Task-file register codes
    localparam logic [2:0] RC_CONTROL = 3'd0;
    localparam logic [2:0] RC_COUNT   = 3'd1;
    localparam logic [2:0] RC_LOW     = 3'd2;
    localparam logic [2:0] RC_MID     = 3'd3;
    localparam logic [2:0] RC_HIGH    = 3'd4;
    localparam logic [2:0] RC_DEVSEL  = 3'd5;
    localparam logic [2:0] RC_COMMAND = 3'd6;

    // Register values
    localparam logic [7:0] CTRL_NIEN    = 8'h02;
    localparam logic [7:0] CTRL_HOB     = 8'h80;
    localparam logic [7:0] DEVSEL_CHS   = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA   = 8'hE0;
    localparam logic [7:0] OP_READ      = 8'h20;
    localparam logic [7:0] OP_READ_EXT  = 8'h24;
    localparam logic [7:0] OP_WRITE     = 8'h30;
    localparam logic [7:0] OP_WRITE_EXT = 8'h34;

    // CHS geometry: divide by 63 as multiply by ceil(2^34/63), shift 34.
    // Exact for any address below 2^28.
    localparam int           CHS_SHIFT = 34;
    localparam logic [28:0]  CHS_RECIP = 29'd272696337;

endpackage

// ===== design/atci_front.sv =====
// Front end: accepts requests, works out addressing mode and register bytes.
module atci_front
    import atci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  request_t    cmd,
    input  logic [3:0]  lba_capable,
    input  logic [3:0]  is_slave,
    input  logic [3:0]  channel_sel,
    output logic        push,
    output issue_desc_t push_desc,
    input  logic        queue_full
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    request_t    s1_req_reg;
    logic [56:0] s1_prod_reg;
    logic        s1_chan_reg;
    logic        s1_slave_reg;
    logic        s1_lba_ok_reg;

    logic        s1_load;
    logic        ext;
    logic [22:0] quot;
    logic [28:0] quot_x63;
    logic [28:0] rem_full;
    logic [7:0]  sector;
    logic [7:0]  slave_bit;

    // Stage one takes a word when empty or when its word moves on
    assign push      = s1_valid_reg && !queue_full;
    assign cmd_ready = !s1_valid_reg || !queue_full;
    assign s1_load   = cmd_valid && cmd_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload and reciprocal product for the CHS divide
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_req_reg    <= cmd;
            s1_prod_reg   <= {1'b0, cmd.block_address[27:0]} * {28'd0, CHS_RECIP};
            s1_chan_reg   <= channel_sel[cmd.device_index];
            s1_slave_reg  <= is_slave[cmd.device_index];
            s1_lba_ok_reg <= lba_capable[cmd.device_index];
        end
    end

    // Stage two: quotient, remainder and register bytes
    always_comb
    begin
        ext       = (s1_req_reg.block_address[31:28] != 4'd0);
        quot      = s1_prod_reg[56:CHS_SHIFT];
        quot_x63  = {quot, 6'd0} - {6'd0, quot};
        rem_full  = {1'b0, s1_req_reg.block_address[27:0]} - quot_x63;
        sector    = {2'd0, rem_full[5:0]} + 8'd1;
        slave_bit = {3'd0, s1_slave_reg, 4'd0};

        push_desc.channel = s1_chan_reg;
        push_desc.ext     = ext;
        push_desc.count   = s1_req_reg.sector_total;
        push_desc.hob_low = s1_req_reg.block_address[31:24];

        if (ext || s1_lba_ok_reg)
        begin
            push_desc.byte_low  = s1_req_reg.block_address[7:0];
            push_desc.byte_mid  = s1_req_reg.block_address[15:8];
            push_desc.byte_high = s1_req_reg.block_address[23:16];
        end
        else
        begin
            push_desc.byte_low  = sector;
            push_desc.byte_mid  = quot[11:4];
            push_desc.byte_high = quot[19:12];
        end

        if (ext)
        begin
            push_desc.devsel = DEVSEL_LBA | slave_bit;
            push_desc.opcode = s1_req_reg.write_request ? OP_WRITE_EXT : OP_READ_EXT;
        end
        else if (s1_lba_ok_reg)
        begin
            push_desc.devsel = DEVSEL_LBA | slave_bit
                             | {4'd0, s1_req_reg.block_address[27:24]};
            push_desc.opcode = s1_req_reg.write_request ? OP_WRITE : OP_READ;
        end
        else
        begin
            push_desc.devsel = DEVSEL_CHS | slave_bit | {4'd0, quot[3:0]};
            push_desc.opcode = s1_req_reg.write_request ? OP_WRITE : OP_READ;
        end
    end

endmodule

// ===== design/atci_queue.sv =====
// Short queue of classified requests between front and back.
module atci_queue
    import atci_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  issue_desc_t push_desc,
    output logic        full,
    input  logic        pop,
    output issue_desc_t head_desc,
    output logic        empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    issue_desc_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    assign full      = (fill_reg == FULL_CNT);
    assign empty     = (fill_reg == '0);
    assign head_desc = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            fill_next = fill_reg + CW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ===== design/atci_back.sv =====
// Back end: task-file write sequence, one word a cycle while tf_ready holds.
module atci_back
    import atci_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  issue_desc_t     head_desc,
    input  logic            empty,
    output logic            pop,
    output logic            tf_valid,
    input  logic            tf_ready,
    output taskfile_write_t tf
);

    // Sequence steps; LBA28 and CHS jump from device select to sector count
    typedef enum logic [18:0] {
        S_CTRL      = 19'h00001,
        S_DEVSEL    = 19'h00002,
        S_HCNT_ON   = 19'h00004,
        S_HCNT      = 19'h00008,
        S_HCNT_OFF  = 19'h00010,
        S_HLOW_ON   = 19'h00020,
        S_HLOW      = 19'h00040,
        S_HLOW_OFF  = 19'h00080,
        S_HMID_ON   = 19'h00100,
        S_HMID      = 19'h00200,
        S_HMID_OFF  = 19'h00400,
        S_HHIGH_ON  = 19'h00800,
        S_HHIGH     = 19'h01000,
        S_HHIGH_OFF = 19'h02000,
        S_COUNT     = 19'h04000,
        S_LOW       = 19'h08000,
        S_MID       = 19'h10000,
        S_HIGH      = 19'h20000,
        S_COMMAND   = 19'h40000
    } step_t;

    step_t           step_reg;
    step_t           step_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    taskfile_write_t out_word_reg;
    taskfile_write_t word;
    logic            advance;

    assign advance  = !empty && (!out_valid_reg || tf_ready);
    assign pop      = advance && (step_reg == S_COMMAND);
    assign tf_valid = out_valid_reg;
    assign tf       = out_word_reg;

    // Word for the current step
    always_comb
    begin
        word.target_channel = head_desc.channel;
        word.final_write    = 1'b0;
        word.register_code  = RC_CONTROL;
        word.write_value    = CTRL_NIEN;
        case (step_reg)
            S_CTRL, S_HCNT_OFF, S_HLOW_OFF, S_HMID_OFF, S_HHIGH_OFF:
            begin
                word.register_code = RC_CONTROL;
                word.write_value   = CTRL_NIEN;
            end
            S_HCNT_ON, S_HLOW_ON, S_HMID_ON, S_HHIGH_ON:
            begin
                word.register_code = RC_CONTROL;
                word.write_value   = CTRL_HOB | CTRL_NIEN;
            end
            S_DEVSEL:
            begin
                word.register_code = RC_DEVSEL;
                word.write_value   = head_desc.devsel;
            end
            S_HCNT:
            begin
                word.register_code = RC_COUNT;
                word.write_value   = 8'd0;
            end
            S_HLOW:
            begin
                word.register_code = RC_LOW;
                word.write_value   = head_desc.hob_low;
            end
            S_HMID:
            begin
                word.register_code = RC_MID;
                word.write_value   = 8'd0;
            end
            S_HHIGH:
            begin
                word.register_code = RC_HIGH;
                word.write_value   = 8'd0;
            end
            S_COUNT:
            begin
                word.register_code = RC_COUNT;
                word.write_value   = head_desc.count;
            end
            S_LOW:
            begin
                word.register_code = RC_LOW;
                word.write_value   = head_desc.byte_low;
            end
            S_MID:
            begin
                word.register_code = RC_MID;
                word.write_value   = head_desc.byte_mid;
            end
            S_HIGH:
            begin
                word.register_code = RC_HIGH;
                word.write_value   = head_desc.byte_high;
            end
            S_COMMAND:
            begin
                word.register_code = RC_COMMAND;
                word.write_value   = head_desc.opcode;
                word.final_write   = 1'b1;
            end
            default:
            begin
                word.register_code = RC_CONTROL;
                word.write_value   = CTRL_NIEN;
            end
        endcase
    end

    // Step sequencer and output register
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            case (step_reg)
                S_CTRL:      step_next = S_DEVSEL;
                S_DEVSEL:    step_next = head_desc.ext ? S_HCNT_ON : S_COUNT;
                S_HCNT_ON:   step_next = S_HCNT;
                S_HCNT:      step_next = S_HCNT_OFF;
                S_HCNT_OFF:  step_next = S_HLOW_ON;
                S_HLOW_ON:   step_next = S_HLOW;
                S_HLOW:      step_next = S_HLOW_OFF;
                S_HLOW_OFF:  step_next = S_HMID_ON;
                S_HMID_ON:   step_next = S_HMID;
                S_HMID:      step_next = S_HMID_OFF;
                S_HMID_OFF:  step_next = S_HHIGH_ON;
                S_HHIGH_ON:  step_next = S_HHIGH;
                S_HHIGH:     step_next = S_HHIGH_OFF;
                S_HHIGH_OFF: step_next = S_COUNT;
                S_COUNT:     step_next = S_LOW;
                S_LOW:       step_next = S_MID;
                S_MID:       step_next = S_HIGH;
                S_HIGH:      step_next = S_COMMAND;
                S_COMMAND:   step_next = S_CTRL;
                default:     step_next = S_CTRL;
            endcase
        end
        else if (tf_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_CTRL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= word;
    end

endmodule

// ===== design/ata_taskfile_command_issuer_unit.sv =====
// Top level of the ATA task-file command issuer: config port, front, queue, back.
//
//  Channel  | Signals                              | Word
//  ---------+--------------------------------------+------------------------
//  request  | cmd_valid, cmd_ready, cmd            | request_t
//  result   | tf_valid, tf_ready, tf               | taskfile_write_t
//  config   | psel, penable, pwrite, paddr, pwdata | 4-bit device masks
//
// A request gives 19 words (LBA48) or 7 (LBA28, CHS), one a cycle from the
// back end's step register while tf_ready holds; it sets the sustained rate.
// The front end takes a new request every cycle while the queue has room,
// so it classifies the next request while the back end still issues.
// Path to the first result word: stage-one register, queue slot, output register.
// Reset clears control state and the device masks; the result channel
// stalls only the back end, the front keeps filling the queue.
module ata_taskfile_command_issuer_unit
    import atci_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  request_t        cmd,
    output logic            tf_valid,
    input  logic            tf_ready,
    output taskfile_write_t tf,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic [1:0] REG_LBA_CAPABLE = 2'd0;
    localparam logic [1:0] REG_IS_SLAVE    = 2'd1;
    localparam logic [1:0] REG_CHANNEL     = 2'd2;

    logic [3:0]  lba_capable_reg;
    logic [3:0]  is_slave_reg;
    logic [3:0]  channel_reg;
    logic        cfg_write;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    issue_desc_t push_desc;
    issue_desc_t head_desc;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_capable_reg <= 4'd0;
            is_slave_reg    <= 4'd0;
            channel_reg     <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LBA_CAPABLE: lba_capable_reg <= pwdata[3:0];
                REG_IS_SLAVE:    is_slave_reg    <= pwdata[3:0];
                REG_CHANNEL:     channel_reg     <= pwdata[3:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LBA_CAPABLE: prdata = {28'd0, lba_capable_reg};
            REG_IS_SLAVE:    prdata = {28'd0, is_slave_reg};
            REG_CHANNEL:     prdata = {28'd0, channel_reg};
            default:         prdata = 32'd0;
        endcase
    end

    atci_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .lba_capable (lba_capable_reg),
        .is_slave    (is_slave_reg),
        .channel_sel (channel_reg),
        .push        (push),
        .push_desc   (push_desc),
        .queue_full  (queue_full)
    );

    atci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (queue_empty)
    );

    atci_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .empty     (queue_empty),
        .pop       (pop),
        .tf_valid  (tf_valid),
        .tf_ready  (tf_ready),
        .tf        (tf)
    );

endmodule

// ===== bench/ata_taskfile_command_issuer_unit_test.sv =====
// Self-checking testbench for the ATA task-file command issuer: directed and random requests.
`timescale 1ns / 1ps

module ata_taskfile_command_issuer_unit_test
    import atci_pkg::*;
();

    // Register map, one 32-bit slot per device mask
    localparam logic [3:0] ADDR_LBA_CAPABLE = 4'h0;
    localparam logic [3:0] ADDR_IS_SLAVE    = 4'h4;
    localparam logic [3:0] ADDR_CHANNEL     = 4'h8;
    localparam logic [3:0] ADDR_UNMAPPED    = 4'hC;

    localparam logic [31:0] LBA48_THRESHOLD = 32'h1000_0000;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          PHASE_REQUESTS  = 44;

    logic            clk;
    logic            rst_n;
    logic            cmd_valid;
    logic            cmd_ready;
    request_t        cmd;
    logic            tf_valid;
    logic            tf_ready;
    taskfile_write_t tf;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [3:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    // Local copy of the device masks
    logic [3:0] lba_capable_mask;
    logic [3:0] slave_mask;
    logic [3:0] channel_mask;

    // Task-file words still owed by the block, oldest first
    taskfile_write_t pending_writes[$];

    int unsigned error_count;
    int unsigned words_checked;
    int unsigned lba48_requests;
    int unsigned lba28_requests;
    int unsigned chs_requests;
    bit          steady;

    ata_taskfile_command_issuer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .tf_valid (tf_valid),
        .tf_ready (tf_ready),
        .tf       (tf),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void push_write(input logic ch, input logic [2:0] code,
                                       input logic [7:0] value, input logic last);
        taskfile_write_t w;
        w.target_channel = ch;
        w.register_code  = code;
        w.write_value    = value;
        w.final_write    = last;
        pending_writes.push_back(w);
    endfunction

    // High-order write, wrapped in HOB-set and HOB-clear control writes
    function automatic void push_hob_write(input logic ch, input logic [2:0] code,
                                           input logic [7:0] value);
        push_write(ch, RC_CONTROL, CTRL_HOB | CTRL_NIEN, 1'b0);
        push_write(ch, code, value, 1'b0);
        push_write(ch, RC_CONTROL, CTRL_NIEN, 1'b0);
    endfunction

    // Works out the register writes one request causes
    function automatic void predict_writes(input request_t r);
        logic        ch;
        logic        slave;
        logic        ext;
        logic [31:0] lba;
        logic [31:0] cyl;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [3:0]  head;
        logic [7:0]  devsel;
        logic [7:0]  opcode;
        ch    = channel_mask[r.device_index];
        slave = slave_mask[r.device_index];
        lba   = r.block_address;
        ext   = 1'b0;
        if (lba >= LBA48_THRESHOLD)
        begin
            ext    = 1'b1;
            b0     = lba[7:0];
            b1     = lba[15:8];
            b2     = lba[23:16];
            head   = 4'h0;
            devsel = DEVSEL_LBA;
            opcode = r.write_request ? OP_WRITE_EXT : OP_READ_EXT;
            lba48_requests++;
        end
        else if (lba_capable_mask[r.device_index])
        begin
            b0     = lba[7:0];
            b1     = lba[15:8];
            b2     = lba[23:16];
            head   = lba[27:24];
            devsel = DEVSEL_LBA;
            opcode = r.write_request ? OP_WRITE : OP_READ;
            lba28_requests++;
        end
        else
        begin
            cyl    = (lba / 32'd1008) & 32'h0000_FFFF;
            b0     = 8'((lba % 32'd63) + 32'd1);
            b1     = cyl[7:0];
            b2     = cyl[15:8];
            head   = 4'((lba / 32'd63) % 32'd16);
            devsel = DEVSEL_CHS;
            opcode = r.write_request ? OP_WRITE : OP_READ;
            chs_requests++;
        end
        push_write(ch, RC_CONTROL, CTRL_NIEN, 1'b0);
        push_write(ch, RC_DEVSEL, devsel | {3'b000, slave, 4'h0} | {4'h0, head}, 1'b0);
        if (ext)
        begin
            push_hob_write(ch, RC_COUNT, 8'h00);
            push_hob_write(ch, RC_LOW, lba[31:24]);
            push_hob_write(ch, RC_MID, 8'h00);
            push_hob_write(ch, RC_HIGH, 8'h00);
        end
        push_write(ch, RC_COUNT, r.sector_total, 1'b0);
        push_write(ch, RC_LOW, b0, 1'b0);
        push_write(ch, RC_MID, b1, 1'b0);
        push_write(ch, RC_HIGH, b2, 1'b0);
        push_write(ch, RC_COMMAND, opcode, 1'b1);
    endfunction

    function automatic request_t make_request(input logic [1:0] dev, input logic wr,
                                              input logic [31:0] addr,
                                              input logic [7:0] count);
        request_t r;
        r.device_index  = dev;
        r.write_request = wr;
        r.block_address = addr;
        r.sector_total  = count;
        return r;
    endfunction

    // Sends one request word; returns at the edge that accepts it
    task automatic send_request(input request_t r);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= r;
        predict_writes(r);
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // Sender holds off until every owed word has come, then lets the block settle
    task automatic drain;
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [3:0] addr, input logic [3:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {28'h0, want})
            flag_error("register read-back", got, {28'h0, want});
    endtask

    // Writes all three masks with junk in the unused bits, then reads them back
    task automatic set_device_masks(input logic [3:0] lba_cap, input logic [3:0] slave,
                                    input logic [3:0] chan);
        apb_write(ADDR_LBA_CAPABLE, {28'($urandom_range(0, 32'h0FFF_FFFF)), lba_cap});
        apb_write(ADDR_IS_SLAVE, {28'($urandom_range(0, 32'h0FFF_FFFF)), slave});
        apb_write(ADDR_CHANNEL, {28'($urandom_range(0, 32'h0FFF_FFFF)), chan});
        lba_capable_mask = lba_cap;
        slave_mask       = slave;
        channel_mask     = chan;
        apb_check(ADDR_LBA_CAPABLE, lba_capable_mask);
        apb_check(ADDR_IS_SLAVE, slave_mask);
        apb_check(ADDR_CHANNEL, channel_mask);
    endtask

    // Mix of plain, boundary and high addresses
    function automatic logic [31:0] pick_address;
        logic [31:0] a;
        case ($urandom_range(0, 5))
            0: a = $urandom;
            1: a = $urandom & 32'h0FFF_FFFF;
            2: a = $urandom_range(0, 4095);
            3: a = 32'h0FFF_FFF8 + $urandom_range(0, 16);
            4: a = $urandom_range(0, 70000) * 32'd1008 + $urandom_range(0, 1);
            default: a = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        endcase
        return a;
    endfunction

    // Receiver: random stall before each word, none while steady is set
    always
    begin : ready_driver
        int unsigned stall;
        stall = steady ? 0 : $urandom_range(0, 5);
        repeat (stall)
        begin
            @(negedge clk);
            tf_ready <= 1'b0;
        end
        @(negedge clk);
        tf_ready <= 1'b1;
        do
            @(posedge clk);
        while (!(tf_valid && rst_n));
    end

    // Compare each accepted word with the oldest owed one
    always @(posedge clk)
    begin : word_checker
        taskfile_write_t want;
        if (rst_n && tf_valid && tf_ready)
        begin
            if (pending_writes.size() == 0)
                flag_error("unexpected word", 32'(tf), 32'h0);
            else
            begin
                want = pending_writes.pop_front();
                words_checked++;
                if (tf.target_channel !== want.target_channel)
                    flag_error("target_channel", 32'(tf.target_channel),
                               32'(want.target_channel));
                if (tf.register_code !== want.register_code)
                    flag_error("register_code", 32'(tf.register_code),
                               32'(want.register_code));
                if (tf.write_value !== want.write_value)
                    flag_error("write_value", 32'(tf.write_value), 32'(want.write_value));
                if (tf.final_write !== want.final_write)
                    flag_error("final_write", 32'(tf.final_write), 32'(want.final_write));
            end
        end
    end

    // Masks at reset value: every device is a CHS master on the primary channel
    task automatic test_reset_defaults;
        apb_check(ADDR_LBA_CAPABLE, 4'h0);
        apb_check(ADDR_IS_SLAVE, 4'h0);
        apb_check(ADDR_CHANNEL, 4'h0);
        send_request(make_request(2'd0, 1'b0, 32'd0, 8'd0));
        send_request(make_request(2'd1, 1'b1, 32'd62, 8'd255));
        send_request(make_request(2'd2, 1'b0, 32'd63, 8'd1));
        send_request(make_request(2'd3, 1'b1, 32'd1007, 8'd128));
        send_request(make_request(2'd0, 1'b0, 32'd1008, 8'd127));
        // cylinder wraps past 16 bits just under the LBA48 threshold
        send_request(make_request(2'd1, 1'b1, 32'h0FFF_FFFF, 8'hAA));
        drain();
    endtask

    // LBA28 on capable devices, with slave and channel bits mixed
    task automatic test_lba28;
        set_device_masks(4'hF, 4'h5, 4'hA);
        send_request(make_request(2'd0, 1'b0, 32'd0, 8'd1));
        send_request(make_request(2'd1, 1'b1, 32'h0FFF_FFFF, 8'd255));
        send_request(make_request(2'd2, 1'b0, 32'h0ABC_DEF1, 8'h55));
        send_request(make_request(2'd3, 1'b1, 32'h0543_2100, 8'd0));
        drain();
    endtask

    // LBA48 whatever the capability bit, both opcodes
    task automatic test_lba48;
        set_device_masks(4'h3, 4'hC, 4'h6);
        send_request(make_request(2'd0, 1'b0, LBA48_THRESHOLD, 8'd0));
        send_request(make_request(2'd3, 1'b1, 32'hFFFF_FFFF, 8'd255));
        send_request(make_request(2'd1, 1'b1, 32'h8000_0001, 8'h0F));
        send_request(make_request(2'd2, 1'b0, 32'h1234_5678, 8'hF0));
        drain();
    endtask

    // Unmapped address is ignored; extreme mask settings
    task automatic test_config_edges;
        set_device_masks(4'hF, 4'hF, 4'hF);
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFF0);
        apb_check(ADDR_LBA_CAPABLE, lba_capable_mask);
        apb_check(ADDR_IS_SLAVE, slave_mask);
        apb_check(ADDR_CHANNEL, channel_mask);
        send_request(make_request(2'd2, 1'b1, 32'h00FE_DCBA, 8'd3));
        send_request(make_request(2'd3, 1'b0, 32'h0000_3F00, 8'd4));
        drain();
        set_device_masks(4'h0, 4'hF, 4'h0);
        send_request(make_request(2'd1, 1'b0, 32'h0765_4321, 8'd9));
        send_request(make_request(2'd2, 1'b1, 32'h0000_0400, 8'd200));
        drain();
        set_device_masks(4'hF, 4'h0, 4'hF);
        send_request(make_request(2'd0, 1'b1, 32'h0F0F_0F0F, 8'd77));
        drain();
    endtask

    // Random requests over several mask settings; one phase without idling
    task automatic test_random_traffic;
        logic [3:0] lba_cap;
        logic [3:0] slave;
        logic [3:0] chan;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                {lba_cap, slave, chan} = 12'h000;
            else if (phase == RANDOM_PHASES - 1)
                {lba_cap, slave, chan} = 12'hFFF;
            else
                {lba_cap, slave, chan} = 12'($urandom);
            set_device_masks(lba_cap, slave, chan);
            steady = (phase == 3);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                send_request(make_request(2'($urandom), 1'($urandom), pick_address(),
                                          8'($urandom)));
                // mid-phase pause until the block has caught up
                if (phase == 5 && n == PHASE_REQUESTS / 2)
                    drain();
            end
            drain();
            steady = 1'b0;
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cmd_valid        = 1'b0;
        cmd              = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        lba_capable_mask = 4'h0;
        slave_mask       = 4'h0;
        channel_mask     = 4'h0;
        error_count      = 0;
        words_checked    = 0;
        lba48_requests   = 0;
        lba28_requests   = 0;
        chs_requests     = 0;
        steady           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_lba28();
        test_lba48();
        test_config_edges();
        test_random_traffic();

        $display("Requests: %0d LBA48, %0d LBA28, %0d CHS over %0d mask settings.",
                 lba48_requests, lba28_requests, chs_requests, RANDOM_PHASES + 6);
        $display("Task-file words checked: %0d, errors: %0d.", words_checked, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
